@@ hw/rtl/spi_eeprom_512b_slave_top_defines.svh @@
// Assertion helpers for the EEPROM slave; clk and rst_n are taken from the using scope.
`ifndef SPI_EEPROM_512B_SLAVE_TOP_DEFINES_SVH
`define SPI_EEPROM_512B_SLAVE_TOP_DEFINES_SVH

// same-cycle implication
`define SE512_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("se512 same-cycle check failed");

// next-cycle implication
`define SE512_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("se512 next-cycle check failed");

`endif

@@ hw/rtl/se512_pkg.sv @@
`timescale 1ns / 1ps
package se512_pkg;

    localparam int MemBytes  = 512;
    localparam int PageBytes = 16;
    localparam int AddrW     = $clog2(MemBytes);
    localparam int PageW     = $clog2(PageBytes);

    // bus event codes
    localparam logic [1:0] FN_SELECT  = 2'd0;
    localparam logic [1:0] FN_RELEASE = 2'd1;
    localparam logic [1:0] FN_XFER    = 2'd2;

    // opcodes, bit 3 masked when bit 7 is clear
    localparam logic [7:0] OP_WRSR  = 8'h01;
    localparam logic [7:0] OP_WRITE = 8'h02;
    localparam logic [7:0] OP_READ  = 8'h03;
    localparam logic [7:0] OP_WRDI  = 8'h04;
    localparam logic [7:0] OP_RDSR  = 8'h05;
    localparam logic [7:0] OP_WREN  = 8'h06;

    localparam logic [7:0] IDLE_BYTE   = 8'hFF;
    localparam logic [7:0] STATUS_BASE = 8'hF0;

    localparam logic [AddrW-1:0] QUARTER_TOP = 9'h180;
    localparam logic [AddrW-1:0] HALF_TOP    = 9'h100;

    localparam logic [1:0] PM_QUARTER = 2'd1;
    localparam logic [1:0] PM_HALF    = 2'd2;
    localparam logic [1:0] PM_ALL     = 2'd3;

    typedef enum logic [2:0] {
        PH_DESEL  = 3'd0,
        PH_OPCODE = 3'd1,
        PH_IDLE   = 3'd2,
        PH_RDSR   = 3'd3,
        PH_WRSR   = 3'd4,
        PH_ADDR   = 3'd5,
        PH_READ   = 3'd6,
        PH_WRITE  = 3'd7
    } phase_t;

    typedef enum logic [2:0] {
        CM_NONE  = 3'd0,
        CM_WREN  = 3'd1,
        CM_WRDI  = 3'd2,
        CM_RDSR  = 3'd3,
        CM_WRSR  = 3'd4,
        CM_READ  = 3'd5,
        CM_WRITE = 3'd6
    } cmd_t;

    typedef struct packed {
        logic             we;
        logic             re;
        logic [AddrW-1:0] addr;
        logic [7:0]       wdata;
    } store_req_t;

endpackage

@@ hw/rtl/se512_bus_if.sv @@
`timescale 1ns / 1ps
interface se512_bus_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] mosi_byte;

    modport source (output valid, output func, output mosi_byte, input ready);
    modport sink   (input valid, input func, input mosi_byte, output ready);
endinterface

@@ hw/rtl/se512_reply_if.sv @@
`timescale 1ns / 1ps
interface se512_reply_if;
    logic       valid;
    logic       ready;
    logic [7:0] miso_byte;

    modport source (output valid, output miso_byte, input ready);
    modport sink   (input valid, input miso_byte, output ready);
endinterface

@@ hw/rtl/se512_store.sv @@
`timescale 1ns / 1ps
module se512_store
    import se512_pkg::*;
(
    input  logic       clk,
    input  store_req_t req,
    output logic [7:0] rdata
);

    logic [7:0] mem [MemBytes];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
        // read data holds until the next read
        if (req.re)
        begin
            rdata_reg <= mem[req.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/spi_eeprom_512b_slave_top.sv @@
`timescale 1ns / 1ps
// channel | dir | words                          | fields
// bus     | in  | select / release / byte xfer   | func[1:0], mosi_byte[7:0]
// reply   | out | one per bus word               | miso_byte[7:0]
//
// One bus word per cycle while bus.ready is high; its reply passes through
// the store read register, then the output register.
// Bus phase, command, address, latch and protect mode sit in flops; the
// 512-byte store is a synchronous RAM with registered read, written at acceptance.
// A stalled reply holds the read stage; bus.ready drops only when both are full.
// Async active-low reset clears control; store contents are not reset.
module spi_eeprom_512b_slave_top
    import se512_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    se512_bus_if.sink     bus,
    se512_reply_if.source reply
);

    `include "spi_eeprom_512b_slave_top_defines.svh"

    phase_t           phase_reg, phase_next;
    cmd_t             cmd_reg, cmd_next;
    logic [AddrW-1:0] addr_reg, addr_next;
    logic             wel_reg, wel_next;
    logic [1:0]       pm_reg, pm_next;

    logic             s1_valid_reg;
    logic             s1_mem_reg;
    logic [7:0]       s1_byte_reg;
    logic             out_valid_reg;
    logic [7:0]       out_byte_reg;

    logic             in_fire;
    logic             s1_adv;
    logic             rsp_mem;
    logic [7:0]       rsp_byte;
    logic [7:0]       key;
    logic             protect_hit;
    store_req_t       store_req;
    logic [7:0]       store_rdata;

    se512_store u_store (
        .clk   (clk),
        .req   (store_req),
        .rdata (store_rdata)
    );

    assign s1_adv    = !out_valid_reg || reply.ready;
    assign bus.ready = !s1_valid_reg || s1_adv;
    assign in_fire   = bus.valid && bus.ready;

    assign key = bus.mosi_byte[7] ? bus.mosi_byte : (bus.mosi_byte & 8'hF7);

    always_comb
    begin
        unique case (pm_reg)
            PM_ALL:     protect_hit = 1'b1;
            PM_HALF:    protect_hit = (addr_reg >= HALF_TOP);
            PM_QUARTER: protect_hit = (addr_reg >= QUARTER_TOP);
            default:    protect_hit = 1'b0;
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        cmd_next   = cmd_reg;
        addr_next  = addr_reg;
        wel_next   = wel_reg;
        pm_next    = pm_reg;
        store_req  = '0;
        store_req.addr  = addr_reg;
        store_req.wdata = bus.mosi_byte;
        rsp_byte   = IDLE_BYTE;
        rsp_mem    = 1'b0;

        if (in_fire)
        begin
            unique case (bus.func)
                FN_SELECT:
                begin
                    if (phase_reg == PH_DESEL)
                    begin
                        phase_next = PH_OPCODE;
                    end
                end
                FN_RELEASE:
                begin
                    if (cmd_reg == CM_WRITE || cmd_reg == CM_WRSR)
                    begin
                        wel_next = 1'b0;
                    end
                    phase_next = PH_DESEL;
                end
                FN_XFER:
                begin
                    unique case (phase_reg)
                        PH_OPCODE:
                        begin
                            unique case (key)
                                OP_WREN:
                                begin
                                    cmd_next   = CM_WREN;
                                    wel_next   = 1'b1;
                                    phase_next = PH_IDLE;
                                end
                                OP_WRDI:
                                begin
                                    cmd_next   = CM_WRDI;
                                    wel_next   = 1'b0;
                                    phase_next = PH_IDLE;
                                end
                                OP_RDSR:
                                begin
                                    cmd_next   = CM_RDSR;
                                    phase_next = PH_RDSR;
                                end
                                OP_WRSR:
                                begin
                                    cmd_next   = CM_WRSR;
                                    phase_next = wel_reg ? PH_WRSR : PH_IDLE;
                                end
                                OP_READ:
                                begin
                                    cmd_next   = CM_READ;
                                    addr_next  = {bus.mosi_byte[3], {(AddrW-1){1'b0}}};
                                    phase_next = PH_ADDR;
                                end
                                OP_WRITE:
                                begin
                                    cmd_next = CM_WRITE;
                                    if (wel_reg)
                                    begin
                                        addr_next  = {bus.mosi_byte[3], {(AddrW-1){1'b0}}};
                                        phase_next = PH_ADDR;
                                    end
                                    else
                                    begin
                                        phase_next = PH_IDLE;
                                    end
                                end
                                default:
                                begin
                                    // unknown opcode: next byte is an opcode again
                                    cmd_next = CM_NONE;
                                end
                            endcase
                        end
                        PH_RDSR:
                        begin
                            rsp_byte = STATUS_BASE | {4'b0, pm_reg, wel_reg, 1'b0};
                        end
                        PH_WRSR:
                        begin
                            wel_next   = bus.mosi_byte[1];
                            pm_next    = bus.mosi_byte[3:2];
                            phase_next = PH_IDLE;
                        end
                        PH_ADDR:
                        begin
                            addr_next  = addr_reg | {1'b0, bus.mosi_byte};
                            phase_next = (cmd_reg == CM_READ) ? PH_READ : PH_WRITE;
                        end
                        PH_READ:
                        begin
                            store_req.re = 1'b1;
                            rsp_mem      = 1'b1;
                            addr_next    = addr_reg + 1'b1;
                        end
                        PH_WRITE:
                        begin
                            if (!protect_hit)
                            begin
                                store_req.we = 1'b1;
                                // wrap inside the page
                                addr_next = {addr_reg[AddrW-1:PageW],
                                             addr_reg[PageW-1:0] + 1'b1};
                            end
                        end
                        default:
                        begin
                            // deselected or idle: byte ignored
                        end
                    endcase
                end
                default:
                begin
                    // undefined bus code: ignored
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_DESEL;
            cmd_reg       <= CM_NONE;
            addr_reg      <= '0;
            wel_reg       <= 1'b0;
            pm_reg        <= 2'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            cmd_reg   <= cmd_next;
            addr_reg  <= addr_next;
            wel_reg   <= wel_next;
            pm_reg    <= pm_next;
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_mem_reg  <= rsp_mem;
            s1_byte_reg <= rsp_byte;
        end
        if (s1_adv && s1_valid_reg)
        begin
            out_byte_reg <= s1_mem_reg ? store_rdata : s1_byte_reg;
        end
    end

    assign reply.valid     = out_valid_reg;
    assign reply.miso_byte = out_byte_reg;

    `SE512_ASSERT_NOW(a_write_in_write_phase, store_req.we,
                      phase_reg == PH_WRITE && pm_reg != PM_ALL)
    `SE512_ASSERT_NOW(a_no_accept_on_stall, s1_valid_reg && !s1_adv, !in_fire)
    `SE512_ASSERT_NEXT(a_release_deselects, in_fire && bus.func == FN_RELEASE, phase_reg == PH_DESEL)
    `SE512_ASSERT_NEXT(a_read_reaches_s1, in_fire && store_req.re, s1_valid_reg && s1_mem_reg)

endmodule
